FILE: rtl/bcc_pkg.sv
// types and constants shared by the button click classifier files
package bcc_pkg;

	localparam int CFG_W   = 16;
	localparam int LIMIT_W = 4;
	localparam int COUNT_W = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

	localparam logic [CFG_W-1:0]   LONG_PRESS_RESET  = 16'd500;
	localparam logic [CFG_W-1:0]   SHORT_PRESS_RESET = 16'd50;
	localparam logic [CFG_W-1:0]   MAX_GAP_RESET     = 16'd800;
	localparam logic [LIMIT_W-1:0] CLICK_LIMIT_RESET = 4'd1;

	typedef enum logic [1:0] {
		CFG_LONG_PRESS  = 2'd0,
		CFG_SHORT_PRESS = 2'd1,
		CFG_MAX_GAP     = 2'd2,
		CFG_CLICK_LIMIT = 2'd3
	} cfg_idx_t;

	typedef logic [COUNT_W-1:0] count_t;

endpackage

FILE: rtl/bcc_if.sv
// channel interfaces of the button click classifier

interface bcc_sample_if;
	logic valid;
	logic ready;
	logic button_level;

	modport source (output valid, output button_level, input ready);
	modport sink (input valid, input button_level, output ready);
endinterface

interface bcc_result_if;
	import bcc_pkg::*;
	logic   valid;
	logic   ready;
	logic   gesture_done;
	count_t long_clicks;
	count_t short_clicks;

	modport source (output valid, output gesture_done, output long_clicks,
		output short_clicks, input ready);
	modport sink (input valid, input gesture_done, input long_clicks,
		input short_clicks, output ready);
endinterface

interface bcc_cfg_if;
	import bcc_pkg::*;
	logic             valid;
	logic             ready;
	cfg_idx_t         index;
	logic [CFG_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/button_click_classifier_unit.sv
// button click classifier: sorts presses into long and short clicks per gesture
//
// channels: sample carries one button level beat per millisecond tick; result
// returns exactly one beat per sample beat, with gesture_done set and both
// click counts on the tick a gesture ends, and all zero otherwise; cfg writes
// the four threshold registers (long press, short press, max gap, click limit)
// and is always ready, to be used only while no sample is in flight.
// path: a sample accepted into the input register is classified in one pass
// of counters and compares and then registered into the result register.
// throughput: one sample per cycle while the result side does not stall; the
// press and gap timers are registers that each tick reads back and updates.
// stall: a valid result register holds while result.ready is low; the input stage
// then fills and sample.ready drops until the result beat is taken.
// reset: arst_n clears the timers, counts and valid flags and loads the
// register defaults of 500, 50, 800 and 1.
// timers saturate at 2^TIMER_BITS - 1, click counts at 31.
module button_click_classifier_unit #(
	parameter int TIMER_BITS = 16
) (
	input logic          clk,
	input logic          arst_n,
	bcc_sample_if.sink   sample,
	bcc_result_if.source result,
	bcc_cfg_if.sink      cfg
);
	import bcc_pkg::*;

	// compare width covering both timer and threshold registers
	localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	// threshold registers
	logic [CFG_W-1:0]   long_press_q;
	logic [CFG_W-1:0]   short_press_q;
	logic [CFG_W-1:0]   max_gap_q;
	logic [LIMIT_W-1:0] click_limit_q;

	// gesture state
	logic                  press_active_q;
	logic [TIMER_BITS-1:0] press_timer_q;
	logic                  gap_active_q;
	logic [TIMER_BITS-1:0] gap_timer_q;
	count_t                long_count_q;
	count_t                short_count_q;

	// input stage
	logic valid_s1;
	logic level_s1;

	// result register
	logic   out_valid_q;
	logic   done_q;
	count_t long_out_q;
	count_t short_out_q;

	logic advance;
	logic out_free;

	// next-state values of one tick
	logic                  press_active_d;
	logic [TIMER_BITS-1:0] press_timer_d;
	logic [TIMER_BITS-1:0] press_tick;
	logic                  gap_active_d;
	logic [TIMER_BITS-1:0] gap_timer_d;
	logic [TIMER_BITS-1:0] gap_tick;
	count_t                long_count_d;
	count_t                short_count_d;
	logic                  is_long;
	logic                  is_short;
	logic [COUNT_W:0]      total;
	logic                  gesture_end;

	// handshakes
	assign out_free     = !out_valid_q || result.ready;
	assign advance      = valid_s1 && out_free;
	assign sample.ready = !valid_s1 || out_free;
	assign cfg.ready    = 1'b1;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q  <= LONG_PRESS_RESET;
			short_press_q <= SHORT_PRESS_RESET;
			max_gap_q     <= MAX_GAP_RESET;
			click_limit_q <= CLICK_LIMIT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_LONG_PRESS:  long_press_q  <= cfg.data;
				CFG_SHORT_PRESS: short_press_q <= cfg.data;
				CFG_MAX_GAP:     max_gap_q     <= cfg.data;
				CFG_CLICK_LIMIT: click_limit_q <= cfg.data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			level_s1 <= sample.button_level;
		end
	end

	// one tick of the classifier
	always_comb begin
		// timers run first, saturating
		gap_tick = gap_timer_q;
		if (gap_active_q && gap_timer_q != TIMER_MAX) begin
			gap_tick = gap_timer_q + 1'b1;
		end
		press_tick = press_timer_q;
		if (press_active_q && press_timer_q != TIMER_MAX) begin
			press_tick = press_timer_q + 1'b1;
		end

		press_active_d = press_active_q;
		press_timer_d  = press_tick;
		gap_active_d   = gap_active_q;
		gap_timer_d    = gap_tick;
		long_count_d   = long_count_q;
		short_count_d  = short_count_q;

		// long test wins over short
		is_long  = CMP_W'(press_tick) >= CMP_W'(long_press_q);
		is_short = !is_long && (CMP_W'(press_tick) >= CMP_W'(short_press_q));

		if (level_s1) begin
			if (!press_active_q) begin
				press_active_d = 1'b1;
				press_timer_d  = '0;
			end
		end else if (press_active_q) begin
			if (is_long && long_count_q != COUNT_MAX) begin
				long_count_d = long_count_q + 1'b1;
			end
			if (is_short && short_count_q != COUNT_MAX) begin
				short_count_d = short_count_q + 1'b1;
			end
			// a counted click restarts the gap timing, a too-short press does not
			if (is_long || is_short) begin
				gap_active_d = 1'b1;
				gap_timer_d  = '0;
			end
			press_active_d = 1'b0;
			press_timer_d  = '0;
		end

		total = {1'b0, long_count_d} + {1'b0, short_count_d};

		// only a released tick can end the gesture
		gesture_end = !level_s1 && (
			(gap_active_d && (CMP_W'(gap_timer_d) > CMP_W'(max_gap_q))) ||
			(total > (COUNT_W + 1)'(click_limit_q)));
	end

	// gesture state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_active_q <= 1'b0;
			press_timer_q  <= '0;
			gap_active_q   <= 1'b0;
			gap_timer_q    <= '0;
			long_count_q   <= '0;
			short_count_q  <= '0;
		end else if (advance) begin
			press_active_q <= press_active_d;
			press_timer_q  <= press_timer_d;
			if (gesture_end) begin
				// report once, then clear the counts and the gap timing
				gap_active_q  <= 1'b0;
				gap_timer_q   <= '0;
				long_count_q  <= '0;
				short_count_q <= '0;
			end else begin
				gap_active_q  <= gap_active_d;
				gap_timer_q   <= gap_timer_d;
				long_count_q  <= long_count_d;
				short_count_q <= short_count_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			done_q      <= gesture_end;
			long_out_q  <= gesture_end ? long_count_d : '0;
			short_out_q <= gesture_end ? short_count_d : '0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.gesture_done = done_q;
	assign result.long_clicks  = long_out_q;
	assign result.short_clicks = short_out_q;

endmodule

FILE: tb/sv/bcc_checker.sv
// scoreboard for the button click classifier: predicts each result beat and compares
module bcc_checker #(
	parameter int TIMER_BITS = 16
) (
	input logic   clk,
	input logic   arst_n,
	bcc_sample_if smp,
	bcc_result_if res,
	bcc_cfg_if    cfg,
	output int    mismatches,
	output int    outstanding
);
	import bcc_pkg::*;

	typedef struct packed {
		logic   gesture_done;
		count_t long_clicks;
		count_t short_clicks;
	} gesture_t;

	localparam logic [TIMER_BITS-1:0] TIMER_TOP = '1;

	// shadow copy of the threshold registers
	logic [CFG_W-1:0]   long_min;
	logic [CFG_W-1:0]   short_min;
	logic [CFG_W-1:0]   gap_max;
	logic [LIMIT_W-1:0] limit;

	// shadow copy of the classifier state
	logic                  held;
	logic [TIMER_BITS-1:0] held_ticks;
	logic                  gap_run;
	logic [TIMER_BITS-1:0] gap_ticks;
	count_t                n_long;
	count_t                n_short;

	gesture_t expected_gestures[$];

	function automatic logic [TIMER_BITS-1:0] timer_up(input logic [TIMER_BITS-1:0] v);
		return (v == TIMER_TOP) ? v : v + 1'b1;
	endfunction

	function automatic count_t count_up(input count_t v);
		return (v == COUNT_MAX) ? v : v + 1'b1;
	endfunction

	// one tick of the classifier, updates the shadow state
	task automatic classify_tick(input logic level, output gesture_t g);
		logic counted;
		counted = 1'b0;
		g = '0;
		if (gap_run)
			gap_ticks = timer_up(gap_ticks);
		if (held)
			held_ticks = timer_up(held_ticks);
		if (level) begin
			if (!held) begin
				held = 1'b1;
				held_ticks = '0;
			end
		end else if (held) begin
			// long test first, so short never wins when its threshold is not lower
			if (held_ticks >= long_min) begin
				n_long = count_up(n_long);
				counted = 1'b1;
			end else if (held_ticks >= short_min) begin
				n_short = count_up(n_short);
				counted = 1'b1;
			end
			if (counted) begin
				gap_run = 1'b1;
				gap_ticks = '0;
			end
			held = 1'b0;
			held_ticks = '0;
		end
		if (!level && ((gap_run && gap_ticks > gap_max) ||
				(int'(n_long) + int'(n_short) > int'(limit)))) begin
			g.gesture_done = 1'b1;
			g.long_clicks = n_long;
			g.short_clicks = n_short;
			n_long = '0;
			n_short = '0;
			gap_run = 1'b0;
			gap_ticks = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		gesture_t g;
		if (!arst_n) begin
			long_min = LONG_PRESS_RESET;
			short_min = SHORT_PRESS_RESET;
			gap_max = MAX_GAP_RESET;
			limit = CLICK_LIMIT_RESET;
			held = 1'b0;
			held_ticks = '0;
			gap_run = 1'b0;
			gap_ticks = '0;
			n_long = '0;
			n_short = '0;
			expected_gestures.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_LONG_PRESS:  long_min = cfg.data;
					CFG_SHORT_PRESS: short_min = cfg.data;
					CFG_MAX_GAP:     gap_max = cfg.data;
					CFG_CLICK_LIMIT: limit = cfg.data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (smp.valid && smp.ready) begin
				classify_tick(smp.button_level, g);
				expected_gestures.push_back(g);
			end
			if (res.valid && res.ready) begin
				if (expected_gestures.size() == 0) begin
					if (mismatches < 10)
						$display("result beat with nothing expected: done=%0d long=%0d short=%0d",
							res.gesture_done, res.long_clicks, res.short_clicks);
					mismatches++;
				end else begin
					g = expected_gestures.pop_front();
					if (res.gesture_done !== g.gesture_done ||
							res.long_clicks !== g.long_clicks ||
							res.short_clicks !== g.short_clicks) begin
						if (mismatches < 10)
							$display("mismatch: expected done=%0d long=%0d short=%0d, got done=%0d long=%0d short=%0d",
								g.gesture_done, g.long_clicks, g.short_clicks,
								res.gesture_done, res.long_clicks, res.short_clicks);
						mismatches++;
					end
				end
			end
			outstanding = expected_gestures.size();
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
// testbench top for the button click classifier: stimulus, flow control and verdict
module tb_top;
	import bcc_pkg::*;

	// cycles without any beat before the run is declared hung
	localparam int WATCHDOG_LIMIT = 3000;
	// one long receiver hold-off so the sample side backs up
	localparam int HOLD_CYCLES    = 300;
	// rough size of the random part, in sample beats
	localparam int RANDOM_ITEMS   = 1050;

	logic clk;
	logic arst_n;

	bcc_sample_if smp();
	bcc_result_if res();
	bcc_cfg_if    cfg();

	int mismatches;
	int outstanding;
	int burst_left;
	int levels_sent;
	bit steady_sender;

	button_click_classifier_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp),
		.result (res),
		.cfg    (cfg)
	);

	bcc_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.smp         (smp),
		.res         (res),
		.cfg         (cfg),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// 10 unit clock period
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// one sample beat; the sender runs in bursts with idle gaps between them
	// unless steady mode is on for the current phase
	task automatic put_level(input logic lvl);
		if (burst_left == 0) begin
			if (!steady_sender) begin
				smp.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		smp.valid <= 1'b1;
		smp.button_level <= lvl;
		do @(posedge clk); while (!smp.ready);
		@(negedge clk);
		burst_left--;
		levels_sent++;
	endtask

	// a press of high_ticks pressed beats followed by low_ticks released beats
	task automatic press(input int high_ticks, input int low_ticks);
		repeat (high_ticks) put_level(1'b1);
		repeat (low_ticks) put_level(1'b0);
	endtask

	// stop sending and wait until every predicted result beat has come back
	task automatic settle;
		smp.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// write all four threshold registers back to back, only while idle
	task automatic load_regs(input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] sp,
			input logic [CFG_W-1:0] mg, input logic [CFG_W-1:0] cl);
		cfg_idx_t         order[4];
		logic [CFG_W-1:0] vals[4];
		order = '{CFG_LONG_PRESS, CFG_SHORT_PRESS, CFG_MAX_GAP, CFG_CLICK_LIMIT};
		vals = '{lp, sp, mg, cl};
		for (int i = 0; i < 4; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= order[i];
			cfg.data <= vals[i];
			do @(posedge clk); while (!cfg.ready);
			@(negedge clk);
		end
		cfg.valid <= 1'b0;
	endtask

	// receiver: segments of random length, each with its own stall pattern
	initial begin
		int  mode;
		int  seg;
		int  seg_count;
		int  tick;
		bit  hold_done;
		res.ready = 1'b0;
		seg_count = 0;
		tick = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			seg = $urandom_range(20, 200);
			repeat (seg) begin
				@(negedge clk);
				tick++;
				case (mode)
					0: res.ready <= 1'b1;                         // no stalls
					1: res.ready <= ($urandom_range(0, 9) < 7);   // light random stalls
					2: res.ready <= ($urandom_range(0, 9) < 3);   // heavy random stalls
					default: res.ready <= (tick % 4 == 0);        // one beat in four
				endcase
			end
			seg_count++;
			// long hold-off while the sender keeps offering, fills the block
			if (!hold_done && seg_count == 4) begin
				@(negedge clk);
				res.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
		end
	end

	// watchdog: ends the run if no beat moves on any channel for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((smp.valid && smp.ready) || (res.valid && res.ready) ||
					(cfg.valid && cfg.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] lp;
		logic [CFG_W-1:0] sp;
		logic [CFG_W-1:0] mg;
		logic [CFG_W-1:0] cl;
		int               phase_start;
		int               phase_len;
		int               high_ticks;
		int               low_ticks;

		// every input known from time zero
		arst_n = 1'b0;
		smp.valid = 1'b0;
		smp.button_level = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_LONG_PRESS;
		cfg.data = '0;
		burst_left = 0;
		levels_sent = 0;
		steady_sender = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset thresholds: a short click then a long one exceeds the limit of one,
		// then a press too short to count
		press(60, 4);
		press(520, 3);
		press(20, 2);
		settle();

		// small thresholds for the directed cases
		load_regs(16'd6, 16'd3, 16'd2, 16'd3);
		press(1, 1);          // discarded press, nothing reported
		press(3, 1);          // short click
		press(2, 1);          // held past the gap, report waits for the release
		press(6, 1);          // long click
		press(3, 1);          // gap expires while held, click restarts the gap
		press(4, 1);
		press(7, 3);          // fourth click exceeds the limit of three
		settle();

		// limit of zero, written with the upper data bits set so they get masked
		load_regs(16'd4, 16'd2, 16'd5, 16'hFFF0);
		press(2, 1);
		press(5, 2);
		settle();

		// short threshold above the long one: nothing is ever short
		load_regs(16'd3, 16'd5, 16'd3, 16'd2);
		press(4, 1);
		press(3, 5);
		press(2, 1);
		settle();

		// lowest thresholds with the largest limit
		load_regs(16'd1, 16'd1, 16'd1, 16'd15);
		press(1, 1);
		press(1, 3);
		settle();

		// random phases, each with its own thresholds
		phase_start = levels_sent;
		while (levels_sent - phase_start < RANDOM_ITEMS) begin
			lp = CFG_W'($urandom_range(2, 24));
			sp = CFG_W'($urandom_range(1, lp + 4));
			mg = CFG_W'($urandom_range(1, 30));
			cl[LIMIT_W-1:0] = ($urandom_range(0, 3) == 0) ? LIMIT_W'($urandom_range(0, 15))
				: LIMIT_W'($urandom_range(1, 4));
			cl[CFG_W-1:LIMIT_W] = (CFG_W - LIMIT_W)'($urandom_range(0, 4095));
			load_regs(lp, sp, mg, cl);
			steady_sender = ($urandom_range(0, 3) == 0);
			phase_len = levels_sent + $urandom_range(150, 300);
			while (levels_sent < phase_len) begin
				if ($urandom_range(0, 9) < 8) begin
					// well formed press around the thresholds
					high_ticks = $urandom_range(1, lp + 6);
					low_ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(mg, mg + 10)
						: $urandom_range(1, mg + 3);
					press(high_ticks, low_ticks);
				end else begin
					// noise: chatter of random levels
					repeat ($urandom_range(1, 8)) put_level(1'($urandom_range(0, 1)));
				end
			end
			settle();
		end

		// let any late beat show up before the verdict
		repeat (10) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
